### hw/rtl/insertion_sorter_defines.svh
// ----------------------------------------------------------------------------
// insertion_sorter_defines
// Assertion macros used by the insertion sorter top level.
// ----------------------------------------------------------------------------
`ifndef INSERTION_SORTER_DEFINES_SVH
`define INSERTION_SORTER_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ISORT_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define ISORT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hw/rtl/isort_pkg.sv
// ----------------------------------------------------------------------------
// isort_pkg
// Types and constants shared by the insertion sorter modules.
// ----------------------------------------------------------------------------
package isort_pkg;

    localparam int DATA_W          = 32;
    localparam int SWAP_W          = 11;
    localparam int MAX_ENTRIES_DEF = 64;
    localparam int GRP_SIZE        = 8;

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_SETTLE,
        ST_EMIT
    } t_isort_state;

    typedef struct packed {
        logic ins;
        logic pop;
    } t_isort_cmd;

    typedef struct packed {
        logic last_entry;
    } t_isort_sts;

endpackage

### hw/rtl/isort_in_if.sv
// ----------------------------------------------------------------------------
// isort_in_if
// Input channel of the insertion sorter: one value per beat.
// ----------------------------------------------------------------------------
interface isort_in_if import isort_pkg::*; ();

    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] value;
    logic                     is_last;

    modport source (output valid, output value, output is_last, input ready);
    modport sink   (input valid, input value, input is_last, output ready);

endinterface

### hw/rtl/isort_out_if.sv
// ----------------------------------------------------------------------------
// isort_out_if
// Output channel of the insertion sorter: one sorted element per beat.
// ----------------------------------------------------------------------------
interface isort_out_if import isort_pkg::*; ();

    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] sorted_value;
    logic                     end_of_run;
    logic [SWAP_W-1:0]        swap_total;
    logic                     overflowed;

    modport source (output valid, output sorted_value, output end_of_run,
                    output swap_total, output overflowed, input ready);
    modport sink   (input valid, input sorted_value, input end_of_run,
                    input swap_total, input overflowed, output ready);

endinterface

### hw/rtl/isort_ctrl.sv
// ----------------------------------------------------------------------------
// isort_ctrl
// Controller: loads a run, waits for the swap count to settle, then drains.
// ----------------------------------------------------------------------------
module isort_ctrl import isort_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic       i_in_last,
    input  logic       i_out_ready,
    input  t_isort_sts i_sts,
    output logic       o_in_ready,
    output logic       o_out_valid,
    output t_isort_cmd o_cmd
);

    t_isort_state r_state;
    t_isort_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_LOAD;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_LOAD: begin
                if (i_in_valid && i_in_last) begin
                    n_state = ST_SETTLE;
                end
            end
            ST_SETTLE: begin
                n_state = ST_EMIT;
            end
            ST_EMIT: begin
                if (i_out_ready && i_sts.last_entry) begin
                    n_state = ST_LOAD;
                end
            end
            default: begin
                n_state = ST_LOAD;
            end
        endcase
    end

    always_comb begin
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        o_cmd       = '0;
        case (r_state)
            ST_LOAD: begin
                o_in_ready = 1'b1;
                o_cmd.ins  = i_in_valid;
            end
            ST_SETTLE: begin
                o_cmd = '0;
            end
            ST_EMIT: begin
                o_out_valid = 1'b1;
                o_cmd.pop   = i_out_ready;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

endmodule

### hw/rtl/isort_datapath.sv
// ----------------------------------------------------------------------------
// isort_datapath
// Row of sorting cells, fill and swap counters, overflow flag.
// ----------------------------------------------------------------------------
module isort_datapath import isort_pkg::*; #(
    parameter int MAX_ENTRIES = MAX_ENTRIES_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_isort_cmd               i_cmd,
    input  logic signed [DATA_W-1:0] i_value,
    output t_isort_sts               o_sts,
    output logic signed [DATA_W-1:0] o_sorted_value,
    output logic                     o_end_of_run,
    output logic [SWAP_W-1:0]        o_swap_total,
    output logic                     o_overflowed
);

    localparam int FILL_W = $clog2(MAX_ENTRIES + 1);
    localparam int NGRP   = (MAX_ENTRIES + GRP_SIZE - 1) / GRP_SIZE;
    localparam int GCNT_W = $clog2(GRP_SIZE + 1);
    localparam int SUM_W  = $clog2(NGRP * GRP_SIZE + 1);
    localparam logic [SWAP_W-1:0] SWAP_MAX = '1;

    logic signed [DATA_W-1:0] r_cell [MAX_ENTRIES];
    logic signed [DATA_W-1:0] n_cell [MAX_ENTRIES];
    logic [FILL_W-1:0]        r_fill;
    logic [SWAP_W-1:0]        r_swap;
    logic                     r_ovf;
    logic [GCNT_W-1:0]        r_grp_cnt [NGRP];
    logic                     r_grp_vld;

    logic [NGRP*GRP_SIZE-1:0] w_gt;
    logic [GCNT_W-1:0]        w_grp_cnt [NGRP];
    logic [SUM_W-1:0]         w_batch;
    logic [SWAP_W:0]          w_swap_sum;
    logic                     w_full;
    logic                     w_ins;
    logic                     w_last_entry;

    assign w_full       = (r_fill == FILL_W'(MAX_ENTRIES));
    assign w_ins        = i_cmd.ins && !w_full;
    assign w_last_entry = (r_fill == FILL_W'(1));

    // Every valid cell compares against the incoming value at once.
    always_comb begin
        w_gt = '0;
        for (int i = 0; i < MAX_ENTRIES; i++) begin
            w_gt[i] = (FILL_W'(i) < r_fill) && (r_cell[i] > i_value);
        end
    end

    // Pop moves cells down; else greater cells move up, value in gap.
    always_comb begin
        for (int i = 0; i < MAX_ENTRIES; i++) begin
            n_cell[i] = r_cell[i];
        end
        if (i_cmd.pop) begin
            for (int i = 0; i < MAX_ENTRIES - 1; i++) begin
                n_cell[i] = r_cell[i + 1];
            end
        end else if (w_ins) begin
            if (w_gt[0] || r_fill == '0) begin
                n_cell[0] = i_value;
            end
            for (int i = 1; i < MAX_ENTRIES; i++) begin
                if (w_gt[i - 1]) begin
                    n_cell[i] = r_cell[i - 1];
                end else if (w_gt[i] || r_fill == FILL_W'(i)) begin
                    n_cell[i] = i_value;
                end
            end
        end
    end

    always_comb begin
        for (int g = 0; g < NGRP; g++) begin
            w_grp_cnt[g] = '0;
            for (int b = 0; b < GRP_SIZE; b++) begin
                w_grp_cnt[g] = w_grp_cnt[g] + GCNT_W'(w_gt[g * GRP_SIZE + b]);
            end
        end
    end

    always_comb begin
        w_batch = '0;
        for (int g = 0; g < NGRP; g++) begin
            w_batch = w_batch + SUM_W'(r_grp_cnt[g]);
        end
        w_swap_sum = {1'b0, r_swap} + (SWAP_W + 1)'(w_batch);
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < MAX_ENTRIES; i++) begin
            r_cell[i] <= n_cell[i];
        end
        if (w_ins) begin
            for (int g = 0; g < NGRP; g++) begin
                r_grp_cnt[g] <= w_grp_cnt[g];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill    <= '0;
            r_swap    <= '0;
            r_ovf     <= 1'b0;
            r_grp_vld <= 1'b0;
        end else begin
            r_grp_vld <= w_ins;
            if (i_cmd.pop) begin
                r_fill <= r_fill - FILL_W'(1);
            end else if (w_ins) begin
                r_fill <= r_fill + FILL_W'(1);
            end
            // drop the run totals once its final beat leaves
            if (i_cmd.pop && w_last_entry) begin
                r_swap <= '0;
                r_ovf  <= 1'b0;
            end else begin
                if (r_grp_vld) begin
                    r_swap <= (w_swap_sum > {1'b0, SWAP_MAX}) ? SWAP_MAX
                                                             : w_swap_sum[SWAP_W-1:0];
                end
                if (i_cmd.ins && w_full) begin
                    r_ovf <= 1'b1;
                end
            end
        end
    end

    assign o_sts.last_entry = w_last_entry;
    assign o_sorted_value   = r_cell[0];
    assign o_end_of_run     = w_last_entry;
    assign o_swap_total     = r_swap;
    assign o_overflowed     = r_ovf;

endmodule

### hw/rtl/insertion_sorter.sv
// ----------------------------------------------------------------------------
// insertion_sorter
// Streaming insertion sort of signed 32-bit values with inversion count.
// ----------------------------------------------------------------------------
// Usage:
//   i_in carries one value per beat; is_last marks the final value of a run.
//   While loading, a beat is taken every cycle: every cell of the sorting
//   row compares with the new value in the same cycle, so one value per
//   cycle goes in. Up to MAX_ENTRIES values are kept; further values of the
//   run are dropped and the overflowed flag is raised for that run.
//   After the last beat, a settle state lets the swap count settle (a
//   two-stage population count), then o_out gives the run in ascending
//   order, one element per cycle while the receiver is ready, from the
//   head of the row. end_of_run marks the largest element; swap_total
//   and overflowed repeat on every beat of the run.
//   No input is taken while a run drains. A stalled receiver holds the
//   current beat on o_out until it is taken.
//   Reset empties the store and clears the counters; the block is then
//   ready for a new run at once.
// ----------------------------------------------------------------------------
`include "insertion_sorter_defines.svh"

module insertion_sorter import isort_pkg::*; #(
    parameter int MAX_ENTRIES = MAX_ENTRIES_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    isort_in_if.sink   i_in,
    isort_out_if.source o_out
);

    t_isort_cmd w_cmd;
    t_isort_sts w_sts;

    isort_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_in_last   (i_in.is_last),
        .i_out_ready (o_out.ready),
        .i_sts       (w_sts),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .o_cmd       (w_cmd)
    );

    isort_datapath #(
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .i_value        (i_in.value),
        .o_sts          (w_sts),
        .o_sorted_value (o_out.sorted_value),
        .o_end_of_run   (o_out.end_of_run),
        .o_swap_total   (o_out.swap_total),
        .o_overflowed   (o_out.overflowed)
    );

    `ISORT_ASSERT_SAME(a_load_or_drain, i_in.ready, !o_out.valid, "input taken during drain")
    `ISORT_ASSERT_NEXT(a_settle_gap, i_in.valid && i_in.ready && i_in.is_last, !i_in.ready && !o_out.valid, "no settle cycle after last beat")
    `ISORT_ASSERT_NEXT(a_run_closes, o_out.valid && o_out.ready && o_out.end_of_run, !o_out.valid && i_in.ready, "drain did not stop at end of run")
    `ISORT_ASSERT_SAME(a_eor_scope, w_cmd.pop, o_out.valid, "shift without output beat")

endmodule

### tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for insertion_sorter. Runs of signed values stream in
// at a random burst rate. A behavioral sorter inside the bench keeps each
// run in order, counts inversions and tracks dropped values. Every sorted
// beat that leaves the block is checked against that prediction, with a
// stalling receiver on the output side.
// ----------------------------------------------------------------------------
module tb;
    import isort_pkg::*;

    localparam int CAP      = MAX_ENTRIES_DEF;
    localparam int SWAP_SAT = (1 << SWAP_W) - 1;
    localparam int TAIL_CYC = 2 * CAP + 10;

    typedef struct {
        logic signed [DATA_W-1:0] value;
        logic                     is_last;
    } t_value_beat;

    typedef struct {
        logic signed [DATA_W-1:0] value;
        logic                     end_of_run;
        logic [SWAP_W-1:0]        swaps;
        logic                     overflow;
    } t_sorted_beat;

    typedef enum int {
        RUN_RANDOM,
        RUN_DESCENDING
    } t_run_shape;

    typedef enum int {
        RX_FREE,
        RX_RANDOM,
        RX_SPARSE,
        RX_BLOCKED
    } t_rx_mode;

    logic i_clk;
    logic i_rst_n;

    isort_in_if  in_bus ();
    isort_out_if out_bus ();

    insertion_sorter #(
        .MAX_ENTRIES(CAP)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_bus),
        .o_out   (out_bus)
    );

    t_value_beat              value_beats[$];
    t_sorted_beat             sorted_expect[$];
    logic signed [DATA_W-1:0] sorted_run[$];
    int                       run_swaps;
    logic                     run_dropped;

    logic     in_taken;
    int       gap_left;
    int       burst_left;
    t_rx_mode rx_mode;
    int       rx_left;
    int       rx_phase;

    int err_count;
    int runs_done;
    int values_in;
    int beats_checked;
    int overflow_runs;
    int peak_swaps;

    // Insert one value the way the sorter does: only strictly greater entries
    // move up. Emit the whole run on the last beat, then empty the store.
    function automatic void take_value(logic signed [DATA_W-1:0] v, logic last);
        int           idx;
        int           moves;
        t_sorted_beat b;
        if (sorted_run.size() < CAP) begin
            idx   = sorted_run.size();
            moves = 0;
            while (idx > 0 && sorted_run[idx-1] > v) begin
                idx--;
                moves++;
            end
            sorted_run.insert(idx, v);
            run_swaps = run_swaps + moves;
            if (run_swaps > SWAP_SAT)
                run_swaps = SWAP_SAT;
        end else begin
            run_dropped = 1'b1;
        end
        if (last) begin
            foreach (sorted_run[k]) begin
                b.value      = sorted_run[k];
                b.end_of_run = (k == sorted_run.size() - 1);
                b.swaps      = run_swaps[SWAP_W-1:0];
                b.overflow   = run_dropped;
                sorted_expect.push_back(b);
            end
            runs_done++;
            if (run_dropped)
                overflow_runs++;
            if (run_swaps > peak_swaps)
                peak_swaps = run_swaps;
            sorted_run.delete();
            run_swaps   = 0;
            run_dropped = 1'b0;
        end
    endfunction

    function automatic logic signed [DATA_W-1:0] pick_value();
        logic signed [DATA_W-1:0] v;
        case ($urandom_range(0, 9))
            5, 6, 7: v = $signed($urandom_range(0, 8)) - 4;
            8: begin
                case ($urandom_range(0, 3))
                    0: v = 32'sh8000_0000;
                    1: v = 32'sh7fff_ffff;
                    2: v = 0;
                    default: v = -1;
                endcase
            end
            9: v = ($urandom_range(0, 1) ? 32'sh8000_0000 : 32'sh7fff_fff0)
                   + $signed($urandom_range(0, 15));
            default: v = $urandom;
        endcase
        return v;
    endfunction

    function automatic void add_beat(logic signed [DATA_W-1:0] v, logic last);
        t_value_beat b;
        b.value   = v;
        b.is_last = last;
        value_beats.push_back(b);
    endfunction

    function automatic void add_run(int len, t_run_shape shape);
        logic signed [DATA_W-1:0] base;
        int                       step;
        base = $signed($urandom_range(0, 32'h3fff_ffff));
        step = $urandom_range(1, 1000);
        for (int k = 0; k < len; k++) begin
            if (shape == RUN_DESCENDING)
                add_beat(base - k * step, k == len - 1);
            else
                add_beat(pick_value(), k == len - 1);
        end
    endfunction

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        i_rst_n        = 1'b0;
        in_bus.valid   = 1'b0;
        in_bus.value   = '0;
        in_bus.is_last = 1'b0;
        out_bus.ready  = 1'b0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
    end

    initial begin
        #5_000_000;
        $display("tb: errors");
        $finish;
    end

    // Drive input beats in bursts with random gaps; advance only on a taken beat.
    always @(negedge i_clk) begin : drive_in
        logic        nxt_valid;
        t_value_beat b;
        nxt_valid = in_bus.valid;
        if (!i_rst_n) begin
            nxt_valid = 1'b0;
        end else if (!in_bus.valid || in_taken) begin
            nxt_valid = 1'b0;
            if (gap_left > 0) begin
                gap_left--;
            end else if (value_beats.size() > 0) begin
                b = value_beats.pop_front();
                in_bus.value   <= b.value;
                in_bus.is_last <= b.is_last;
                nxt_valid = 1'b1;
                if (burst_left > 0) begin
                    burst_left--;
                end else begin
                    burst_left = $urandom_range(1, 40);
                    gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                end
            end
        end
        in_bus.valid <= nxt_valid;
    end

    // Stall the receiver in stretches of changing character.
    always @(negedge i_clk) begin : drive_ready
        logic r;
        if (rx_left == 0) begin
            rx_mode = t_rx_mode'($urandom_range(0, 3));
            rx_left = (rx_mode == RX_BLOCKED) ? $urandom_range(3, 25)
                                              : $urandom_range(20, 80);
        end else begin
            rx_left--;
        end
        rx_phase++;
        case (rx_mode)
            RX_FREE:    r = 1'b1;
            RX_RANDOM:  r = $urandom_range(0, 1);
            RX_SPARSE:  r = (rx_phase % 4 == 0);
            default:    r = 1'b0;
        endcase
        out_bus.ready <= r;
    end

    always @(posedge i_clk) begin : watch
        t_sorted_beat e;
        in_taken <= i_rst_n && in_bus.valid && in_bus.ready;
        if (i_rst_n && in_bus.valid && in_bus.ready) begin
            values_in++;
            take_value(in_bus.value, in_bus.is_last);
        end
        if (i_rst_n && out_bus.valid && out_bus.ready) begin
            if (sorted_expect.size() == 0) begin
                $error("unexpected sorted beat: sorted_value %0d", out_bus.sorted_value);
                err_count++;
            end else begin
                e = sorted_expect.pop_front();
                beats_checked++;
                if (out_bus.sorted_value !== e.value) begin
                    $error("sorted_value: expected %0d, got %0d", e.value,
                           out_bus.sorted_value);
                    err_count++;
                end
                if (out_bus.end_of_run !== e.end_of_run) begin
                    $error("end_of_run: expected %0b, got %0b", e.end_of_run,
                           out_bus.end_of_run);
                    err_count++;
                end
                if (out_bus.swap_total !== e.swaps) begin
                    $error("swap_total: expected %0d, got %0d", e.swaps,
                           out_bus.swap_total);
                    err_count++;
                end
                if (out_bus.overflowed !== e.overflow) begin
                    $error("overflowed: expected %0b, got %0b", e.overflow,
                           out_bus.overflowed);
                    err_count++;
                end
            end
        end
    end

    initial begin : stimulus
        int random_items;
        int run_no;
        int len;
        in_taken      = 1'b0;
        gap_left      = 0;
        burst_left    = 0;
        rx_mode       = RX_FREE;
        rx_left       = 0;
        rx_phase      = 0;
        run_swaps     = 0;
        run_dropped   = 1'b0;
        err_count     = 0;
        runs_done     = 0;
        values_in     = 0;
        beats_checked = 0;
        overflow_runs = 0;
        peak_swaps    = 0;

        // Directed: single-value runs at both extremes, mixed extremes,
        // equal values, a full reversal and an already sorted run.
        add_beat(32'sh7fff_ffff, 1'b1);
        add_beat(32'sh8000_0000, 1'b1);
        add_beat(0, 1'b0);
        add_beat(-1, 1'b0);
        add_beat(32'sh7fff_ffff, 1'b0);
        add_beat(32'sh8000_0000, 1'b0);
        add_beat(1, 1'b1);
        for (int k = 0; k < 4; k++)
            add_beat(5, k == 3);
        for (int k = 7; k >= 0; k--)
            add_beat(k, k == 0);
        for (int k = -2; k <= 1; k++)
            add_beat(k, k == 1);

        // Random runs, with a full reversed store (worst swap count), a run
        // that drops exactly its last value, and a longer overflowing run.
        random_items = 0;
        run_no       = 0;
        while (random_items < 270) begin
            if (run_no == 2) begin
                len = CAP;
                add_run(len, RUN_DESCENDING);
            end else begin
                if (run_no == 5)
                    len = CAP + 1;
                else if (run_no == 9)
                    len = CAP + $urandom_range(2, 7);
                else if ($urandom_range(0, 9) < 7)
                    len = $urandom_range(1, 12);
                else if ($urandom_range(0, 3) != 0)
                    len = $urandom_range(13, 40);
                else
                    len = $urandom_range(41, CAP);
                add_run(len, RUN_RANDOM);
            end
            random_items += len;
            run_no++;
        end

        wait (i_rst_n);
        do
            @(negedge i_clk);
        while (value_beats.size() != 0 || in_bus.valid || sorted_expect.size() != 0);
        repeat (TAIL_CYC) @(posedge i_clk);

        $display("summary: %0d runs, %0d values taken, %0d sorted beats checked",
                 runs_done, values_in, beats_checked);
        $display("summary: %0d runs with dropped values, largest swap total %0d",
                 overflow_runs, peak_swaps);
        if (err_count == 0 && sorted_expect.size() == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

endmodule
